@@ rtl/core/relay_outputs_with_auto_off_timers_defines.svh @@
// Assertion shorthands used by the checker.
`ifndef RELAY_OUTPUTS_WITH_AUTO_OFF_TIMERS_DEFINES_SVH
`define RELAY_OUTPUTS_WITH_AUTO_OFF_TIMERS_DEFINES_SVH

// Same-cycle implication, switched off while reset is held.
`define RLYTO_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, switched off while reset is held.
`define RLYTO_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/rlyto_pkg.sv @@
`default_nettype none

package rlyto_pkg;

    localparam int TIMER_WIDTH = 24;
    localparam int CFG_DATA_W  = 24;
    localparam int CFG_IDX_W   = 2;
    localparam int WORD_W      = 16;
    localparam int STATUS_W    = 2;
    localparam int M_TDATA_W   = 24;

    localparam logic [WORD_W-1:0] LIGHT_MASK = 16'h1FFF;
    localparam int LAMP_BIT  = 13;
    localparam int DIR_BIT   = 14;
    localparam int MOTOR_BIT = 15;

    localparam logic [TIMER_WIDTH-1:0] MOTOR_RUN_RST  = TIMER_WIDTH'(30000);
    localparam logic [TIMER_WIDTH-1:0] LAMP_SHORT_RST = TIMER_WIDTH'(60000);
    localparam logic [TIMER_WIDTH-1:0] LAMP_LONG_RST  = TIMER_WIDTH'(600000);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MOTOR_RUN  = 2'd0,
        REG_LAMP_SHORT = 2'd1,
        REG_LAMP_LONG  = 2'd2
    } cfg_reg_t;

    typedef enum logic {
        ACT_TOGGLE = 1'b0,
        ACT_TICK   = 1'b1
    } action_t;

    typedef enum logic [STATUS_W-1:0] {
        LAMP_STOPPED = 2'd0,
        LAMP_SHORT   = 2'd1,
        LAMP_LONG    = 2'd2
    } lamp_status_t;

    typedef struct packed {
        logic tick;
        logic load;
        logic cancel;
    } timer_ctrl_t;

    typedef struct packed {
        logic running;
        logic expire;
        logic running_next;
    } timer_stat_t;

    // Register data is 24 bits wide; fit it to the counter width.
    function automatic logic [TIMER_WIDTH-1:0] fit_timer(input logic [CFG_DATA_W-1:0] v);
        logic [TIMER_WIDTH+CFG_DATA_W-1:0] ext;
        ext = {{TIMER_WIDTH{1'b0}}, v};
        return ext[TIMER_WIDTH-1:0];
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/relay_outputs_with_auto_off_timers.sv @@
// Channel   | Direction | Transaction carries
// ----------+-----------+----------------------------------------------------
// s_        | in        | tuser: action; tdata: press_mask
// m_        | out       | tdata: output_word, lamp_timer_status (zero padded)
// cfg_      | in        | write of one timer register, no read-back
//
// One item per clock: the relay word and both countdowns update in the cycle
// the item is accepted, and the result appears in the output register next.
// s_tready stays high while the output register is empty or being taken,
// so a stalled output holds only its single result.
// Reset (aresetn low, synchronous) clears the relay word, both timers and the
// output valid flag (not the output data), and loads the register reset values.
`default_nettype none

module relay_outputs_with_auto_off_timers (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    input  wire logic [15:0]                        s_tdata,  // [15:0] press_mask
    input  wire logic [0:0]                         s_tuser,  // [0] action
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    // [15:0] output_word, [17:16] lamp_timer_status, [23:18] zero
    output logic [rlyto_pkg::M_TDATA_W-1:0]         m_tdata,
    input  wire logic                               cfg_wr_en,
    input  wire logic [rlyto_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [rlyto_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import rlyto_pkg::*;

    logic [TIMER_WIDTH-1:0] motor_run_reg, lamp_short_reg, lamp_long_reg;

    logic [WORD_W-1:0]      relay_reg, relay_next;
    logic                   is_long_reg, is_long_next;
    logic                   m_valid_reg;
    logic [M_TDATA_W-1:0]   m_data_reg;

    logic                   accept;
    logic [WORD_W-1:0]      mask;
    action_t                action;
    timer_ctrl_t            motor_ctrl, lamp_ctrl;
    timer_stat_t            motor_stat, lamp_stat;
    logic [TIMER_WIDTH-1:0] lamp_load;
    lamp_status_t           status_next;

    assign s_tready = aresetn && (!m_valid_reg || m_tready);
    assign accept   = s_tvalid && s_tready;
    assign mask     = s_tdata;
    assign action   = action_t'(s_tuser[0]);

    // Timer registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            motor_run_reg  <= MOTOR_RUN_RST;
            lamp_short_reg <= LAMP_SHORT_RST;
            lamp_long_reg  <= LAMP_LONG_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_MOTOR_RUN:  motor_run_reg  <= fit_timer(cfg_data);
                REG_LAMP_SHORT: lamp_short_reg <= fit_timer(cfg_data);
                REG_LAMP_LONG:  lamp_long_reg  <= fit_timer(cfg_data);
                default: ;
            endcase
        end
    end

    always_comb begin
        relay_next   = relay_reg;
        is_long_next = is_long_reg;
        motor_ctrl   = '0;
        lamp_ctrl    = '0;
        lamp_load    = lamp_short_reg;
        if (accept) begin
            unique case (action)
                ACT_TICK: begin
                    motor_ctrl.tick = 1'b1;
                    lamp_ctrl.tick  = 1'b1;
                    if (motor_stat.expire) begin
                        relay_next[MOTOR_BIT] = 1'b0;
                    end
                    if (lamp_stat.expire) begin
                        relay_next[LAMP_BIT] = 1'b0;
                        is_long_next         = 1'b0;
                    end
                end
                ACT_TOGGLE: begin
                    relay_next = relay_reg ^ (mask & LIGHT_MASK);
                    if (mask[DIR_BIT] || mask[MOTOR_BIT]) begin
                        relay_next[DIR_BIT] = !mask[DIR_BIT];
                        if (relay_reg[MOTOR_BIT]) begin
                            motor_ctrl.cancel       = 1'b1;
                            relay_next[MOTOR_BIT]   = 1'b0;
                        end else begin
                            motor_ctrl.load         = 1'b1;
                            relay_next[MOTOR_BIT]   = 1'b1;
                        end
                    end
                    if (mask[LAMP_BIT]) begin
                        if (relay_reg[LAMP_BIT]) begin
                            if (lamp_stat.running && !is_long_reg) begin
                                // second press within the short timeout extends
                                lamp_ctrl.load = 1'b1;
                                lamp_load      = lamp_long_reg;
                                is_long_next   = 1'b1;
                            end else begin
                                lamp_ctrl.cancel     = 1'b1;
                                is_long_next         = 1'b0;
                                relay_next[LAMP_BIT] = 1'b0;
                            end
                        end else begin
                            lamp_ctrl.load       = 1'b1;
                            is_long_next         = 1'b0;
                            relay_next[LAMP_BIT] = 1'b1;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        if (!lamp_stat.running_next) begin
            status_next = LAMP_STOPPED;
        end else if (is_long_next) begin
            status_next = LAMP_LONG;
        end else begin
            status_next = LAMP_SHORT;
        end
    end

    rlyto_timer u_motor_timer (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctrl       (motor_ctrl),
        .load_value (motor_run_reg),
        .stat       (motor_stat)
    );

    rlyto_timer u_lamp_timer (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctrl       (lamp_ctrl),
        .load_value (lamp_load),
        .stat       (lamp_stat)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            relay_reg   <= '0;
            is_long_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            relay_reg   <= relay_next;
            is_long_reg <= is_long_next;
            if (accept) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_data_reg <= {{(M_TDATA_W - WORD_W - STATUS_W){1'b0}}, status_next, relay_next};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

`default_nettype wire

@@ rtl/core/rlyto_timer.sv @@
`default_nettype none

module rlyto_timer (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire rlyto_pkg::timer_ctrl_t           ctrl,
    input  wire logic [rlyto_pkg::TIMER_WIDTH-1:0] load_value,
    output rlyto_pkg::timer_stat_t                stat
);
    import rlyto_pkg::*;

    logic [TIMER_WIDTH-1:0] count_reg, count_next;
    logic                   run_reg, run_next;
    logic                   last;

    // A count of 0 or 1 runs out on the next tick.
    assign last = (count_reg[TIMER_WIDTH-1:1] == '0);

    always_comb begin
        count_next = count_reg;
        run_next   = run_reg;
        if (ctrl.load) begin
            count_next = load_value;
            run_next   = 1'b1;
        end else if (ctrl.cancel) begin
            count_next = '0;
            run_next   = 1'b0;
        end else if (ctrl.tick && run_reg) begin
            if (last) begin
                count_next = '0;
                run_next   = 1'b0;
            end else begin
                count_next = count_reg - TIMER_WIDTH'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            run_reg   <= 1'b0;
        end else begin
            count_reg <= count_next;
            run_reg   <= run_next;
        end
    end

    assign stat.running      = run_reg;
    assign stat.expire       = ctrl.tick && run_reg && last && !ctrl.load && !ctrl.cancel;
    assign stat.running_next = run_next;

endmodule

`default_nettype wire

@@ rtl/core/rlyto_chk.sv @@
`default_nettype none
`include "relay_outputs_with_auto_off_timers_defines.svh"

module rlyto_chk (
    input wire logic                             aclk,
    input wire logic                             aresetn,
    input wire logic                             s_tvalid,
    input wire logic                             s_tready,
    input wire logic [15:0]                      s_tdata,
    input wire logic [0:0]                       s_tuser,
    input wire logic                             m_tvalid,
    input wire logic                             m_tready,
    input wire logic [rlyto_pkg::M_TDATA_W-1:0]  m_tdata,
    input wire logic                             cfg_wr_en,
    input wire logic [rlyto_pkg::CFG_IDX_W-1:0]  cfg_index,
    input wire logic [rlyto_pkg::CFG_DATA_W-1:0] cfg_data
);
    import rlyto_pkg::*;

    logic unused_ok;
    assign unused_ok = ^{s_tdata, s_tuser, s_tvalid, cfg_wr_en, cfg_index, cfg_data};

    // Held result must not change while the sink stalls.
    `RLYTO_ASSERT_NEXT(a_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed under stall")

    // A running lamp timer always means the lamp output is on.
    `RLYTO_ASSERT_SAME(a_lamp_on, aclk, aresetn, m_tvalid && (m_tdata[17:16] != 2'd0), m_tdata[LAMP_BIT], "lamp timer running with lamp off")

    // Status code three never occurs and the padding stays zero.
    `RLYTO_ASSERT_SAME(a_status, aclk, aresetn, m_tvalid, (m_tdata[17:16] != 2'd3) && (m_tdata[23:18] == 6'd0), "bad status or padding")

    // Input is never refused while the output register is free.
    `RLYTO_ASSERT_SAME(a_ready, aclk, aresetn, !m_tvalid || m_tready, s_tready, "input stalled with free output")

endmodule

bind relay_outputs_with_auto_off_timers rlyto_chk u_rlyto_chk (.*);

`default_nettype wire
